>>> rtl/group_scaled_quant_matvec_assert.svh
// Assertion macros shared by the matrix-vector block.
`ifndef GROUP_SCALED_QUANT_MATVEC_ASSERT_SVH
`define GROUP_SCALED_QUANT_MATVEC_ASSERT_SVH

// A property that must hold at every clock edge out of reset.
`define GSQ_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// A condition that forces a consequence in the following cycle.
`define GSQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/gsq_pkg.sv
// Package with the shared constants and command/status types of the block.
`default_nettype none

package gsq_pkg;

	// Activation store depth and derived address width.
	localparam int MAX_INPUT = 4096;
	localparam int ADDR_W    = $clog2(MAX_INPUT);

	// Configuration register indexes.
	localparam logic [1:0] CFG_MODE  = 2'd0;
	localparam logic [1:0] CFG_GSIZE = 2'd1;
	localparam logic [1:0] CFG_ILEN  = 2'd2;

	// Item opcodes.
	localparam logic OPC_LOAD   = 1'b0;
	localparam logic OPC_WEIGHT = 1'b1;

	// Weight modes.
	localparam logic MODE_INT8 = 1'b0;
	localparam logic MODE_INT4 = 1'b1;

	// Nibble decode.
	localparam logic [3:0]        NIB_MASK   = 4'hF;
	localparam logic signed [8:0] NIB_OFFSET = 9'sd8;

	// Rounding constant for the Q1.14 scale and the 48-bit clamp limits.
	localparam logic signed [55:0] ROUND_HALF = 56'sd8192;
	localparam logic [47:0]        ROW_MAX    = 48'h7FFF_FFFF_FFFF;
	localparam logic [47:0]        ROW_MIN    = 48'h8000_0000_0000;

	// Reset values of the configuration registers.
	localparam logic [12:0] GSIZE_RST = 13'd32;
	localparam logic [12:0] ILEN_RST  = 13'd4096;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic latch;   // capture the weight byte and scale of an accepted word
		logic wr;      // write one activation
		logic rd;      // read the activation at the current position
		logic mac;     // multiply-accumulate one weight
		logic nib;     // selects the high nibble in 4-bit mode
		logic mul;     // multiply the group sum by the scale
		logic acc;     // add the scaled group into the row sum
		logic rc_clr;  // clear the recompute accumulator
		logic rc_mod;  // one step of the position-in-group search
		logic rc_len;  // one step of the padded row length search
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic gend;      // current weight closes a group
		logic rend;      // current weight closes the row
		logic last;      // the last accumulated weight closed the row
		logic mod_done;  // position-in-group search finished
		logic len_done;  // row length search finished
	} stat_t;

endpackage

`default_nettype wire

>>> rtl/group_scaled_quant_matvec.sv
// Load item: busy stays low. Weight item: a read and a MAC step per weight, then the scale multiply
// and the add when a group closes; a packed 4-bit byte runs its two nibbles in turn.
// The result strobe rises in the cycle after the row's last add; the receiver cannot stall.
// A configuration write starts a recompute of the group position and then the padded row
// length, busy meanwhile.
// Reset (arst_n low) clears the row state and counters; the activation store is not cleared.
`default_nettype none

module group_scaled_quant_matvec import gsq_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic               opcode,
	input  wire logic [11:0]        act_index,
	input  wire logic signed [15:0] act_value,
	input  wire logic [7:0]         weight_byte,
	input  wire logic signed [15:0] group_scale,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [12:0]        cfg_data,
	output logic signed [47:0]      row_result,
	output logic [15:0]             row_index,
	output logic                    done
);

	cmd_t        cmd;
	stat_t       stat;
	logic        mode;
	logic [12:0] g_eff;
	logic [12:0] n_eff;
	logic        cfg_wr;

	// A configuration word lands when valid meets ready.
	assign cfg_wr = cfg_valid && cfg_ready;

	gsq_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_wr),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.mode     (mode),
		.g_eff    (g_eff),
		.n_eff    (n_eff)
	);

	gsq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.opcode    (opcode),
		.cfg_valid (cfg_valid),
		.mode      (mode),
		.stat      (stat),
		.busy      (busy),
		.cfg_ready (cfg_ready),
		.cmd       (cmd)
	);

	gsq_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.mode        (mode),
		.g_eff       (g_eff),
		.n_eff       (n_eff),
		.act_index   (act_index),
		.act_value   (act_value),
		.weight_byte (weight_byte),
		.group_scale (group_scale),
		.stat        (stat),
		.row_result  (row_result),
		.row_index   (row_index),
		.done        (done)
	);

endmodule

`default_nettype wire

>>> rtl/gsq_cfg.sv
// Configuration registers and the effective group size and row length.
`default_nettype none

module gsq_cfg import gsq_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        wr_en,
	input  wire logic [1:0]  wr_index,
	input  wire logic [12:0] wr_data,
	output logic             mode,
	output logic [12:0]      g_eff,
	output logic [12:0]      n_eff
);

	logic        mode_q;
	logic [12:0] gsize_q;
	logic [12:0] ilen_q;

	// Register writes; an index beyond the list is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_INT8;
			gsize_q <= GSIZE_RST;
			ilen_q  <= ILEN_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				CFG_MODE:  mode_q  <= wr_data[0];
				CFG_GSIZE: gsize_q <= wr_data;
				CFG_ILEN:  ilen_q  <= wr_data;
				default: begin
				end
			endcase
		end
	end

	// A zero group size acts as one; the row length is clamped to the store.
	always_comb begin
		mode  = mode_q;
		g_eff = (gsize_q == '0) ? 13'd1 : gsize_q;
		if (ilen_q == '0) begin
			n_eff = 13'd1;
		end else if (ilen_q > 13'(MAX_INPUT)) begin
			n_eff = 13'(MAX_INPUT);
		end else begin
			n_eff = ilen_q;
		end
	end

endmodule

`default_nettype wire

>>> rtl/gsq_ctrl.sv
// Controller state machine that sequences loads, weights, scaling and recompute.
`default_nettype none
`include "group_scaled_quant_matvec_assert.svh"

module gsq_ctrl import gsq_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  start,
	input  wire logic  opcode,
	input  wire logic  cfg_valid,
	input  wire logic  mode,
	input  wire stat_t stat,
	output logic       busy,
	output logic       cfg_ready,
	output cmd_t       cmd
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_RD   = 3'd1;
	localparam logic [2:0] S_MAC  = 3'd2;
	localparam logic [2:0] S_MUL  = 3'd3;
	localparam logic [2:0] S_ACC  = 3'd4;
	localparam logic [2:0] S_RCM  = 3'd5;
	localparam logic [2:0] S_RCL  = 3'd6;

	logic [2:0] state_q, state_d;
	logic       nib_q, nib_d;
	logic       more_nib;

	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = (state_q == S_IDLE) && !start;

	// A packed byte still has its high nibble to run unless the row ended.
	assign more_nib = (mode == MODE_INT4) && !nib_q && !stat.last;

	// Next state and commands.
	always_comb begin
		state_d = state_q;
		nib_d   = nib_q;
		cmd     = '0;
		cmd.nib = nib_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.latch = 1'b1;
					if (opcode == OPC_WEIGHT) begin
						cmd.rd  = 1'b1;
						nib_d   = 1'b0;
						state_d = S_MAC;
					end else begin
						cmd.wr = 1'b1;
					end
				end else if (cfg_valid) begin
					cmd.rc_clr = 1'b1;
					state_d    = S_RCM;
				end
			end
			S_RD: begin
				cmd.rd  = 1'b1;
				state_d = S_MAC;
			end
			S_MAC: begin
				cmd.mac = 1'b1;
				if (stat.gend || stat.rend) begin
					state_d = S_MUL;
				end else if ((mode == MODE_INT4) && !nib_q) begin
					nib_d   = 1'b1;
					state_d = S_RD;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_ACC;
			end
			S_ACC: begin
				cmd.acc = 1'b1;
				if (more_nib) begin
					nib_d   = 1'b1;
					state_d = S_RD;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_RCM: begin
				cmd.rc_mod = 1'b1;
				if (stat.mod_done) begin
					state_d = S_RCL;
				end
			end
			S_RCL: begin
				cmd.rc_len = 1'b1;
				if (stat.len_done) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			nib_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			nib_q   <= nib_d;
		end
	end

	`GSQ_ASSERT(a_cfg_not_busy, !(busy && cfg_ready), "config taken while busy")
	`GSQ_ASSERT_NEXT(a_weight_to_mac, start && !busy && (opcode == OPC_WEIGHT),
		state_q == S_MAC, "accepted weight word did not reach the MAC step")
	`GSQ_ASSERT_NEXT(a_mul_then_acc, cmd.mul, cmd.acc, "scale multiply not followed by add")

endmodule

`default_nettype wire

>>> rtl/gsq_dp.sv
// Datapath: activation store, weight MAC, group scaling, row sum and recompute.
`default_nettype none
`include "group_scaled_quant_matvec_assert.svh"

module gsq_dp import gsq_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire cmd_t               cmd,
	input  wire logic               mode,
	input  wire logic [12:0]        g_eff,
	input  wire logic [12:0]        n_eff,
	input  wire logic [11:0]        act_index,
	input  wire logic signed [15:0] act_value,
	input  wire logic [7:0]         weight_byte,
	input  wire logic signed [15:0] group_scale,
	output stat_t                   stat,
	output logic signed [47:0]      row_result,
	output logic [15:0]             row_index,
	output logic                    done
);

	logic signed [15:0] act_mem [MAX_INPUT];
	logic signed [15:0] act_q;
	logic [7:0]         byte_q;
	logic signed [15:0] scale_q;

	logic [12:0]        pos_q;
	logic [12:0]        gcnt_q;
	logic [13:0]        len_q;
	logic [13:0]        acc_q;
	logic               last_q;
	logic signed [39:0] group_sum_q;
	logic signed [47:0] row_sum_q;
	logic [15:0]        row_cnt_q;
	logic signed [55:0] prod_s1;
	logic signed [47:0] row_result_q;
	logic [15:0]        row_index_q;
	logic               done_q;

	logic [3:0]         nib;
	logic signed [8:0]  w;
	logic signed [24:0] wprod;
	logic               p_lt_n;
	logic [13:0]        pos_inc;
	logic [13:0]        acc_add;
	logic signed [55:0] rnd;
	logic signed [48:0] scaled;
	logic signed [48:0] tsum;
	logic signed [47:0] tsat;

	// Activation store: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (cmd.wr) begin
			act_mem[act_index[ADDR_W-1:0]] <= act_value;
		end
		if (cmd.rd) begin
			act_q <= act_mem[pos_q[ADDR_W-1:0]];
		end
	end

	// Word capture.
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			byte_q  <= weight_byte;
			scale_q <= group_scale;
		end
	end

	// Weight decode and product with the activation.
	always_comb begin
		nib = cmd.nib ? (byte_q[7:4] & NIB_MASK) : (byte_q[3:0] & NIB_MASK);
		if (mode == MODE_INT8) begin
			w = {byte_q[7], byte_q};
		end else begin
			w = $signed({5'b0, nib}) - NIB_OFFSET;
		end
		wprod   = w * act_q;
		p_lt_n  = (pos_q < n_eff);
		pos_inc = {1'b0, pos_q} + 14'd1;
		acc_add = acc_q + {1'b0, g_eff};
	end

	// Status toward the controller.
	always_comb begin
		stat.gend     = ({1'b0, gcnt_q} + 14'd1) == {1'b0, g_eff};
		stat.rend     = (pos_inc >= len_q);
		stat.last     = last_q;
		stat.mod_done = (acc_add > {1'b0, pos_q});
		stat.len_done = (acc_q >= {1'b0, n_eff});
	end

	// Rounding, scaling back to Q.12 and the clamped row sum.
	always_comb begin
		rnd    = prod_s1 + ROUND_HALF;
		scaled = {{7{rnd[55]}}, rnd[55:14]};
		tsum   = {row_sum_q[47], row_sum_q} + scaled;
		if (tsum[48] != tsum[47]) begin
			tsat = tsum[48] ? ROW_MIN : ROW_MAX;
		end else begin
			tsat = tsum[47:0];
		end
	end

	// Scale product stage.
	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			prod_s1 <= group_sum_q * scale_q;
		end
	end

	// Row position, group counter, padded length and the recompute sweep.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			gcnt_q <= '0;
			len_q  <= 14'(MAX_INPUT);
			acc_q  <= '0;
			last_q <= 1'b0;
		end else begin
			if (cmd.mac) begin
				last_q <= stat.rend;
				if (stat.rend) begin
					pos_q  <= '0;
					gcnt_q <= '0;
				end else begin
					pos_q  <= pos_inc[12:0];
					gcnt_q <= stat.gend ? 13'd0 : gcnt_q + 13'd1;
				end
			end
			if (cmd.rc_clr) begin
				acc_q <= '0;
			end else if (cmd.rc_mod) begin
				if (stat.mod_done) begin
					gcnt_q <= pos_q - acc_q[12:0];
					acc_q  <= '0;
				end else begin
					acc_q <= acc_add;
				end
			end else if (cmd.rc_len) begin
				if (stat.len_done) begin
					len_q <= acc_q;
				end else begin
					acc_q <= acc_add;
				end
			end
		end
	end

	// Group and row accumulators and the result word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_sum_q <= '0;
			row_sum_q   <= '0;
			row_cnt_q   <= '0;
			done_q      <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cmd.mul) begin
				group_sum_q <= '0;
			end else if (cmd.mac && p_lt_n) begin
				group_sum_q <= group_sum_q + {{15{wprod[24]}}, wprod};
			end
			if (cmd.acc) begin
				if (last_q) begin
					row_sum_q <= '0;
					row_cnt_q <= row_cnt_q + 16'd1;
					done_q    <= 1'b1;
				end else begin
					row_sum_q <= tsat;
				end
			end
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (cmd.acc && last_q) begin
			row_result_q <= tsat;
			row_index_q  <= row_cnt_q;
		end
	end

	assign row_result = row_result_q;
	assign row_index  = row_index_q;
	assign done       = done_q;

	`GSQ_ASSERT_NEXT(a_done_single, done, !done, "result strobe longer than one cycle")
	`GSQ_ASSERT_NEXT(a_grp_clear, cmd.mul, group_sum_q == '0, "group sum not cleared")
	`GSQ_ASSERT_NEXT(a_done_from_acc, cmd.acc && last_q, done, "row end gave no result")

endmodule

`default_nettype wire
